[hdl/tmc_pkg.sv]
// ----------------------------------------------------------------------------
// tmc_pkg
// Shared types and constants of the tile map collision step.
// ----------------------------------------------------------------------------
package tmc_pkg;

  localparam int POS_W      = 26;     // signed Q.8 positions while a step runs
  localparam int TILE_W     = 18;     // signed tile index
  localparam int DIV_QB     = 17;     // quotient bits of the tile divider
  localparam int DIVIDEND_W = 23;     // biased whole-pixel dividend
  localparam int TILE_BIAS  = 32768;  // tiles added so the dividend stays positive
  localparam int STORE_ROWS = 64;
  localparam int ROW_AW     = 6;
  localparam int PROD_W     = 41;

  localparam logic [1:0] REG_GRAVITY = 2'd0;
  localparam logic [1:0] REG_BOX_W   = 2'd1;
  localparam logic [1:0] REG_BOX_H   = 2'd2;

  typedef enum logic [1:0] {
    MUL_GRAV,
    MUL_VX,
    MUL_VY,
    MUL_SNAP
  } mul_op_t;

  typedef enum logic [1:0] {
    DIV_EDGE,
    DIV_FIRST,
    DIV_LAST
  } div_sel_t;

  typedef struct packed {
    logic               kind;
    logic [5:0]         row_index;
    logic [63:0]        row_bits;
    logic [18:0]        pos_x;
    logic [18:0]        pos_y;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic [15:0]        time_step;
  } step_in_t;

  typedef struct packed {
    logic [18:0]        new_x;
    logic [18:0]        new_y;
    logic signed [23:0] new_vel_x;
    logic signed [23:0] new_vel_y;
    logic               grounded;
  } step_out_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [20:0] value;
  } cfg_wr_t;

  typedef struct packed {
    logic     accept;
    logic     axis;      // 0 horizontal pass, 1 vertical pass
    logic     mul_go;
    mul_op_t  mul_op;
    logic     vy_grav;
    logic     pos_move;
    logic     div_go;
    div_sel_t div_sel;
    logic     scan_init;
    logic     scan_read;
    logic     scan_next;
    logic     snap;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic vel_nz;
    logic div_done;
    logic scan_end;
    logic hit;
    logic out_busy;
  } dp_stat_t;

endpackage

[hdl/tmc_chan_if.sv]
// ----------------------------------------------------------------------------
// tmc_chan_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface tmc_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/tmc_divider.sv]
// ----------------------------------------------------------------------------
// tmc_divider
// Floor division by a constant through a reciprocal multiply; the quotient
// is ready in the cycle after start.
// ----------------------------------------------------------------------------
module tmc_divider #(
  parameter int DIVISOR = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [tmc_pkg::DIVIDEND_W-1:0]     dividend,
  output logic                               done,
  output logic [tmc_pkg::DIV_QB-1:0]         quotient
);

  localparam int QB = tmc_pkg::DIV_QB;
  localparam int DW = tmc_pkg::DIVIDEND_W;
  localparam int SH = DW + $clog2(DIVISOR);
  localparam int RW = DW + 2;
  localparam longint RECIP_L = ((longint'(1) << SH) + longint'(DIVISOR) - 1) /
                               longint'(DIVISOR);
  localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

  logic [DW+RW-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  // rounded-up reciprocal is exact for every dividend of DW bits
  always_ff @(posedge clk) begin
    if (start) begin
      prod <= dividend * RECIP;
    end
  end

  assign quotient = prod[SH +: QB];

endmodule

[hdl/tmc_ctrl.sv]
// ----------------------------------------------------------------------------
// tmc_ctrl
// Sequencer of a step: gravity, move, tile divisions, scan, snap, result.
// ----------------------------------------------------------------------------
module tmc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_kind,
  output logic                req_ready,
  input  tmc_pkg::dp_stat_t   stat,
  output tmc_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_GRAV,
    ST_VX,
    ST_XMOVE,
    ST_YMUL,
    ST_YMOVE,
    ST_EDGE_GO,
    ST_EDGE_WAIT,
    ST_FIRST_GO,
    ST_FIRST_WAIT,
    ST_LAST_GO,
    ST_LAST_WAIT,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SNAP_MUL,
    ST_SNAP_SET,
    ST_FIN
  } state_t;

  state_t state;
  state_t state_next;
  logic   axis;

  always_comb begin
    cmd        = '0;
    cmd.axis   = axis;
    cmd.mul_op = tmc_pkg::MUL_GRAV;
    cmd.div_sel = tmc_pkg::DIV_EDGE;
    req_ready  = 1'b0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        req_ready  = 1'b1;
        cmd.accept = req_valid;
        if (req_valid && req_kind) begin
          state_next = ST_GRAV;
        end
      end
      ST_GRAV: begin
        cmd.mul_go = 1'b1;
        cmd.mul_op = tmc_pkg::MUL_GRAV;
        state_next = ST_VX;
      end
      ST_VX: begin
        cmd.vy_grav = 1'b1;
        cmd.mul_go  = 1'b1;
        cmd.mul_op  = tmc_pkg::MUL_VX;
        state_next  = ST_XMOVE;
      end
      ST_XMOVE: begin
        cmd.pos_move = 1'b1;
        state_next   = stat.vel_nz ? ST_EDGE_GO : ST_YMUL;
      end
      ST_YMUL: begin
        cmd.mul_go = 1'b1;
        cmd.mul_op = tmc_pkg::MUL_VY;
        state_next = ST_YMOVE;
      end
      ST_YMOVE: begin
        cmd.pos_move = 1'b1;
        state_next   = stat.vel_nz ? ST_EDGE_GO : ST_FIN;
      end
      ST_EDGE_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = tmc_pkg::DIV_EDGE;
        state_next  = ST_EDGE_WAIT;
      end
      ST_EDGE_WAIT: begin
        if (stat.div_done) state_next = ST_FIRST_GO;
      end
      ST_FIRST_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = tmc_pkg::DIV_FIRST;
        state_next  = ST_FIRST_WAIT;
      end
      ST_FIRST_WAIT: begin
        if (stat.div_done) state_next = ST_LAST_GO;
      end
      ST_LAST_GO: begin
        cmd.div_go    = 1'b1;
        cmd.div_sel   = tmc_pkg::DIV_LAST;
        cmd.scan_init = 1'b1;
        state_next    = ST_LAST_WAIT;
      end
      ST_LAST_WAIT: begin
        if (stat.div_done) state_next = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        if (stat.scan_end) begin
          state_next = axis ? ST_FIN : ST_YMUL;
        end else begin
          cmd.scan_read = 1'b1;
          state_next    = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (stat.hit) begin
          state_next = ST_SNAP_MUL;
        end else begin
          cmd.scan_next = 1'b1;
          state_next    = ST_SCAN_RD;
        end
      end
      ST_SNAP_MUL: begin
        cmd.mul_go = 1'b1;
        cmd.mul_op = tmc_pkg::MUL_SNAP;
        state_next = ST_SNAP_SET;
      end
      ST_SNAP_SET: begin
        cmd.snap   = 1'b1;
        state_next = axis ? ST_FIN : ST_YMUL;
      end
      ST_FIN: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      axis  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        axis <= 1'b0;
      end else if (state == ST_YMUL) begin
        axis <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_div_done_waiting: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> (state == ST_EDGE_WAIT || state == ST_FIRST_WAIT ||
                       state == ST_LAST_WAIT))
    else $error("tile division finished outside a wait state");

  a_step_starts: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && req_valid && req_kind) |=> state == ST_GRAV)
    else $error("accepted step did not start");

  a_result_leaves: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && !stat.out_busy) |=> (state == ST_IDLE && stat.out_busy))
    else $error("result word not loaded");
`endif

endmodule

[hdl/tmc_dp.sv]
// ----------------------------------------------------------------------------
// tmc_dp
// Datapath: registers, shared multiplier, tile divider, solid map, result.
// ----------------------------------------------------------------------------
module tmc_dp #(
  parameter int TILE_PIXELS = 32,
  parameter int MAP_COLUMNS = 64,
  parameter int MAP_ROWS    = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tmc_pkg::ctrl_cmd_t   cmd,
  output tmc_pkg::dp_stat_t    stat,
  input  tmc_pkg::step_in_t    req_data,
  input  logic                 cfg_valid,
  input  tmc_pkg::cfg_wr_t     cfg_data,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output tmc_pkg::step_out_t   rsp_data
);

  localparam int PW  = tmc_pkg::POS_W;
  localparam int TW  = tmc_pkg::TILE_W;
  localparam int DW  = tmc_pkg::DIVIDEND_W;
  localparam int QB  = tmc_pkg::DIV_QB;
  localparam int AW  = tmc_pkg::ROW_AW;
  localparam int MW  = tmc_pkg::PROD_W;
  localparam int TILE_Q8 = TILE_PIXELS * 256;
  localparam int EXT_X   = MAP_COLUMNS * TILE_Q8 - 1;
  localparam int EXT_Y   = MAP_ROWS * TILE_Q8 - 1;
  localparam int MAX_XI  = (EXT_X > 524287) ? 524287 : EXT_X;
  localparam int MAX_YI  = (EXT_Y > 524287) ? 524287 : EXT_Y;
  localparam int BIAS_PXI = tmc_pkg::TILE_BIAS * TILE_PIXELS;

  localparam logic signed [PW-1:0] MAX_X     = PW'(MAX_XI);
  localparam logic signed [PW-1:0] MAX_Y     = PW'(MAX_YI);
  localparam logic signed [PW-1:0] ONE_PIXEL = PW'(256);
  localparam logic signed [16:0]   TILE_MUL  = 17'(TILE_Q8);
  localparam logic signed [PW-1:0] BIAS_PX   = PW'(BIAS_PXI);
  localparam logic signed [TW-1:0] BIAS_T    = TW'(tmc_pkg::TILE_BIAS);
  localparam logic signed [TW-1:0] COLS_T    = TW'(MAP_COLUMNS);
  localparam logic signed [TW-1:0] ROWS_T    = TW'(MAP_ROWS);
  localparam logic signed [TW-1:0] STORE_T   = TW'(tmc_pkg::STORE_ROWS);

  // configuration
  logic signed [20:0] gravity;
  logic [8:0]         box_w;
  logic [8:0]         box_h;

  // step registers
  logic [15:0]        dt;
  logic signed [23:0] vx;
  logic signed [23:0] vy;
  logic signed [PW-1:0] x_pos;
  logic signed [PW-1:0] y_pos;
  logic               grounded;
  logic signed [MW-1:0] prod;
  logic signed [TW-1:0] t_edge;
  logic signed [TW-1:0] t_first;
  logic signed [TW-1:0] t_last;
  logic signed [TW-1:0] idx;
  tmc_pkg::div_sel_t  div_sel;

  // solid map
  logic [63:0] solid_mem [tmc_pkg::STORE_ROWS];
  logic [tmc_pkg::STORE_ROWS-1:0] row_valid;
  logic [63:0] rd_row;
  logic        rd_ok;
  logic [5:0]  col_q;
  logic        oom_q;
  logic        beyond_q;

  logic signed [PW-1:0] w_ext;
  logic signed [PW-1:0] h_ext;
  logic signed [PW-1:0] size_ext;
  logic                 dir_pos;
  logic signed [23:0]   mul_a;
  logic signed [16:0]   mul_b;
  logic signed [24:0]   disp;
  logic signed [PW-1:0] vy_sum;
  logic signed [23:0]   vy_sat;
  logic signed [TW-1:0] t_adj;
  logic signed [PW-1:0] div_arg;
  logic signed [PW-1:0] div_px;
  logic [DW-1:0]        dividend;
  logic                 div_done;
  logic [QB-1:0]        div_q;
  logic signed [TW-1:0] tile_res;
  logic signed [TW-1:0] col;
  logic signed [TW-1:0] row;
  logic signed [PW-1:0] snapped;

  assign w_ext    = PW'({box_w, 8'h00});
  assign h_ext    = PW'({box_h, 8'h00});
  assign size_ext = cmd.axis ? h_ext : w_ext;
  assign dir_pos  = cmd.axis ? !vy[23] : !vx[23];
  assign disp     = prod[MW-1:16];
  assign t_adj    = dir_pos ? t_edge : t_edge + TW'(1);

  always_comb begin
    unique case (cmd.mul_op)
      tmc_pkg::MUL_GRAV: begin
        mul_a = {{3{gravity[20]}}, gravity};
        mul_b = $signed({1'b0, dt});
      end
      tmc_pkg::MUL_VX: begin
        mul_a = vx;
        mul_b = $signed({1'b0, dt});
      end
      tmc_pkg::MUL_VY: begin
        mul_a = vy;
        mul_b = $signed({1'b0, dt});
      end
      default: begin
        mul_a = {{(24 - TW){t_adj[TW-1]}}, t_adj};
        mul_b = TILE_MUL;
      end
    endcase
  end

  always_comb begin
    vy_sum = PW'(vy) + PW'(disp);
    if (vy_sum > PW'(8388607)) begin
      vy_sat = 24'sh7FFFFF;
    end else if (vy_sum < -PW'(8388608)) begin
      vy_sat = -24'sh800000;
    end else begin
      vy_sat = vy_sum[23:0];
    end
  end

  // leading edge, then first and last tile across the box
  always_comb begin
    case (cmd.div_sel)
      tmc_pkg::DIV_EDGE: begin
        if (cmd.axis) div_arg = dir_pos ? y_pos + h_ext : y_pos;
        else          div_arg = dir_pos ? x_pos + w_ext : x_pos;
      end
      tmc_pkg::DIV_FIRST: div_arg = cmd.axis ? x_pos : y_pos;
      default: begin
        div_arg = cmd.axis ? x_pos + w_ext - ONE_PIXEL : y_pos + h_ext - ONE_PIXEL;
      end
    endcase
  end

  // floor to whole pixels, then bias so the divided value stays positive
  assign div_px   = (div_arg >>> 8) + BIAS_PX;
  assign dividend = DW'(div_px);

  tmc_divider #(
    .DIVISOR (TILE_PIXELS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_go),
    .dividend (dividend),
    .done     (div_done),
    .quotient (div_q)
  );

  assign tile_res = $signed({1'b0, div_q}) - BIAS_T;
  assign col      = cmd.axis ? idx : t_edge;
  assign row      = cmd.axis ? t_edge : idx;
  assign snapped  = prod[PW-1:0] - (dir_pos ? size_ext : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity <= '0;
      box_w   <= 9'd32;
      box_h   <= 9'd32;
    end else if (cfg_valid) begin
      unique case (cfg_data.index)
        tmc_pkg::REG_GRAVITY: gravity <= $signed(cfg_data.value);
        tmc_pkg::REG_BOX_W:   box_w   <= cfg_data.value[8:0];
        tmc_pkg::REG_BOX_H:   box_h   <= cfg_data.value[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dt       <= req_data.time_step;
      vx       <= req_data.vel_x;
      vy       <= req_data.vel_y;
      x_pos    <= PW'(req_data.pos_x);
      y_pos    <= PW'(req_data.pos_y);
      grounded <= 1'b0;
    end
    if (cmd.mul_go) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.vy_grav) begin
      vy <= vy_sat;
    end
    if (cmd.pos_move) begin
      if (cmd.axis) y_pos <= y_pos + PW'(disp);
      else          x_pos <= x_pos + PW'(disp);
    end
    if (cmd.div_go) begin
      div_sel <= cmd.div_sel;
    end
    if (div_done) begin
      case (div_sel)
        tmc_pkg::DIV_EDGE:  t_edge  <= tile_res;
        tmc_pkg::DIV_FIRST: t_first <= tile_res;
        default:            t_last  <= tile_res;
      endcase
    end
    if (cmd.scan_init) begin
      idx <= t_first;
    end else if (cmd.scan_next) begin
      idx <= idx + TW'(1);
    end
    if (cmd.scan_read) begin
      col_q    <= col[5:0];
      oom_q    <= col < 0 || row < 0 || col >= COLS_T || row >= ROWS_T;
      beyond_q <= row >= STORE_T;
    end
    if (cmd.snap) begin
      if (cmd.axis) begin
        y_pos    <= snapped;
        vy       <= '0;
        grounded <= dir_pos;
      end else begin
        x_pos <= snapped;
        vx    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && !req_data.kind) begin
      solid_mem[req_data.row_index] <= req_data.row_bits;
    end
    if (cmd.scan_read) begin
      rd_row <= solid_mem[row[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_ok     <= 1'b0;
    end else begin
      if (cmd.accept && !req_data.kind) begin
        row_valid[req_data.row_index] <= 1'b1;
      end
      if (cmd.scan_read) begin
        rd_ok <= row_valid[row[AW-1:0]];
      end
    end
  end

  // result word holds until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (x_pos < 0)          rsp_data.new_x <= '0;
      else if (x_pos > MAX_X) rsp_data.new_x <= MAX_X[18:0];
      else                    rsp_data.new_x <= x_pos[18:0];
      if (y_pos < 0)          rsp_data.new_y <= '0;
      else if (y_pos > MAX_Y) rsp_data.new_y <= MAX_Y[18:0];
      else                    rsp_data.new_y <= y_pos[18:0];
      rsp_data.new_vel_x <= vx;
      rsp_data.new_vel_y <= vy;
      rsp_data.grounded  <= grounded;
    end
  end

  assign stat.vel_nz   = cmd.axis ? (vy != '0) : (vx != '0);
  assign stat.div_done = div_done;
  assign stat.scan_end = idx > t_last;
  assign stat.hit      = oom_q | (!beyond_q & rd_ok & rd_row[col_q]);
  assign stat.out_busy = rsp_valid;

endmodule

[hdl/tile_map_collision_step.sv]
// ----------------------------------------------------------------------------
// tile_map_collision_step
// Box against solid tile map collision step in fixed point.
// ----------------------------------------------------------------------------
//  channel | dir | word       | accepted when
//  req     | in  | step_in_t  | req.valid & req.ready
//  rsp     | out | step_out_t | rsp.valid & rsp.ready
//  cfg     | in  | cfg_wr_t   | cfg.valid & cfg.ready (always ready)
//
//  A row load is written at its accept and the controller stays idle. After the
//  accept a step runs gravity and both moves and, per axis with nonzero
//  velocity, three tile divisions, a read and a check per scanned tile, and
//  a close of the scan or a snap.
//  Reset clears the solid map valid bits at once; no sweep is needed.
//  A finished result waits in the output register; the next item is taken
//  while it waits, and a later result holds until that word is taken.
module tile_map_collision_step #(
  parameter int TILE_PIXELS = 32,
  parameter int MAP_COLUMNS = 64,
  parameter int MAP_ROWS    = 64
) (
  input logic clk,
  input logic rst,
  tmc_chan_if.sink   req,
  tmc_chan_if.source rsp,
  tmc_chan_if.sink   cfg
);

  tmc_pkg::ctrl_cmd_t cmd;
  tmc_pkg::dp_stat_t  stat;

  assign cfg.ready = 1'b1;

  tmc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_kind  (req.data.kind),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tmc_dp #(
    .TILE_PIXELS (TILE_PIXELS),
    .MAP_COLUMNS (MAP_COLUMNS),
    .MAP_ROWS    (MAP_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req_data  (req.data),
    .cfg_valid (cfg.valid),
    .cfg_data  (cfg.data),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
  );

endmodule
